@@ rtl/ugnc_pkg.sv @@
// Package: shared types, codes and the seven-point stencil table of the neighbor cell search.
package ugnc_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_DIM_X    = 3'd0;
    localparam logic [2:0] REG_DIM_Y    = 3'd1;
    localparam logic [2:0] REG_DIM_Z    = 3'd2;
    localparam logic [2:0] REG_ORIGIN_X = 3'd3;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd5;
    localparam logic [2:0] REG_SPACING  = 3'd6;

    // Query source codes
    localparam logic [1:0] SRC_GRID   = 2'd0;
    localparam logic [1:0] SRC_INDEX  = 2'd1;
    localparam logic [1:0] SRC_WORLD  = 2'd2;
    localparam logic [1:0] SRC_UNUSED = 2'd3;

    // Neighborhood mode codes
    localparam logic MODE_BOX     = 1'b0;
    localparam logic MODE_STENCIL = 1'b1;

    // Shared divider width: dividend bits, one quotient bit per cycle
    localparam int DIVW = 33;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_WPREP,
        S_DIV,
        S_DIVDONE,
        S_CHECK,
        S_CAND,
        S_MUL2,
        S_OUT,
        S_EMPTY
    } state_t;

    typedef enum logic [2:0] {
        PH_IDXZ,
        PH_IDXY,
        PH_WX,
        PH_WY,
        PH_WZ
    } phase_t;

    // Stencil offset of one axis: center, then +x, -x, +y, -y, +z, -z
    function automatic logic signed [1:0] sten_off(input logic [2:0] step,
                                                   input logic [1:0] axis);
        logic signed [1:0] v;
        v = 2'sd0;
        unique case (step)
            3'd1: v = (axis == 2'd0) ?  2'sd1 : 2'sd0;
            3'd2: v = (axis == 2'd0) ? -2'sd1 : 2'sd0;
            3'd3: v = (axis == 2'd1) ?  2'sd1 : 2'sd0;
            3'd4: v = (axis == 2'd1) ? -2'sd1 : 2'sd0;
            3'd5: v = (axis == 2'd2) ?  2'sd1 : 2'sd0;
            3'd6: v = (axis == 2'd2) ? -2'sd1 : 2'sd0;
            default: v = 2'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/uniform_grid_neighbor_cells_core.sv @@
// Module: neighbor cell search of a 3-D uniform grid with a shared iterative divider.
//
// One query enters on the slave stream and produces a run of neighbor cells on the master
// stream, closed by tlast; a query outside the grid gives a single result flagged empty.
// The block holds s_tready low while it works on a query. A grid-coordinate query goes from
// setup through the bounds check to its first candidate; a linear-index query takes setup, two
// passes through the restoring divider with a hand-over state each, and the bounds check;
// world-position queries take setup, a divider pass per axis, and the bounds check.
// Each emitted cell then passes through candidate, multiply and output load, and each
// candidate that falls off the grid is skipped in the candidate state. An empty result is
// loaded in its own state. s_tready rises in the cycle after the final result is loaded.
// Output stalls hold the block in its output and empty states until the output slot is free.
module uniform_grid_neighbor_cells_core #(
    parameter int MAX_DIM    = 1024,
    parameter int MAX_RADIUS = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration writes
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_data,
    // query stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // query_i[11:0] query_j[23:12] query_k[35:24] query_index[65:36] pos_x[97:66]
    // pos_y[129:98] pos_z[161:130] radius_cells[165:162] radius_world[196:166]
    input  logic [199:0] s_tdata,
    // mode[0] source[2:1]
    input  logic [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // cell_i[9:0] cell_j[19:10] cell_k[29:20] cell_index[59:30]
    output logic [63:0]  m_tdata,
    // empty_res[0]
    output logic         m_tuser,
    output logic         m_tlast
);
    import ugnc_pkg::*;

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int PW  = 2 * DW;
    localparam int CW  = DW + 2;
    localparam int CQW = 34;

    // configuration registers
    logic [10:0]        dim_x_reg, dim_y_reg, dim_z_reg;
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [30:0]        spacing_reg;

    // sequencer and datapath registers
    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [199:0]         qd_reg, qd_next;
    logic [2:0]           qu_reg, qu_next;
    logic                 r_reg, r_next;
    logic signed [CQW-1:0] ci_reg, ci_next, cj_reg, cj_next, ck_reg, ck_next;
    logic [31:0]          rem_reg, rem_next;
    logic [DIVW-1:0]      quo_reg, quo_next;
    logic [30:0]          dvs_reg, dvs_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [PW-1:0]        plane_reg, plane_next;
    logic signed [1:0]    oi_reg, oi_next, oj_reg, oj_next, ok_reg, ok_next;
    logic [2:0]           step_reg, step_next;
    logic [DW-1:0]        ni_reg, ni_next, nj_reg, nj_next, nk_reg, nk_next;
    logic                 last_reg, last_next;
    logic [PW-1:0]        p1_reg, p1_next;
    logic [3*DW-1:0]      p2_reg, p2_next;
    logic                 mv_reg, mv_next;
    logic [63:0]          md_reg, md_next;
    logic                 mu_reg, mu_next;
    logic                 ml_reg, ml_next;

    // effective dimensions and spacing
    logic [DW-1:0] d0, d1, d2;
    logic [30:0]   h;
    logic          out_free;
    logic          out_load;

    // divider step
    logic [31:0] trial;
    logic        ge;

    assign d0 = (dim_x_reg > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_x_reg);
    assign d1 = (dim_y_reg > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_y_reg);
    assign d2 = (dim_z_reg > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_z_reg);
    assign h  = (spacing_reg == 31'd0) ? 31'd1 : spacing_reg;

    assign trial    = {rem_reg[30:0], quo_reg[DIVW-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign out_free = !mv_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg   <= '0;
            dim_y_reg   <= '0;
            dim_z_reg   <= '0;
            org_x_reg   <= '0;
            org_y_reg   <= '0;
            org_z_reg   <= '0;
            spacing_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DIM_X:    dim_x_reg   <= cfg_data[10:0];
                REG_DIM_Y:    dim_y_reg   <= cfg_data[10:0];
                REG_DIM_Z:    dim_z_reg   <= cfg_data[10:0];
                REG_ORIGIN_X: org_x_reg   <= cfg_data;
                REG_ORIGIN_Y: org_y_reg   <= cfg_data;
                REG_ORIGIN_Z: org_z_reg   <= cfg_data;
                REG_SPACING:  spacing_reg <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        qd_reg    <= qd_next;
        qu_reg    <= qu_next;
        r_reg     <= r_next;
        ci_reg    <= ci_next;
        cj_reg    <= cj_next;
        ck_reg    <= ck_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        cnt_reg   <= cnt_next;
        plane_reg <= plane_next;
        oi_reg    <= oi_next;
        oj_reg    <= oj_next;
        ok_reg    <= ok_next;
        step_reg  <= step_next;
        ni_reg    <= ni_next;
        nj_reg    <= nj_next;
        nk_reg    <= nk_next;
        last_reg  <= last_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
        ml_reg    <= ml_next;
    end

    // sequencer: next state and datapath
    always_comb
    begin
        logic signed [32:0]   wa;
        logic signed [31:0]   wpos, worg;
        logic signed [CW-1:0] ci_n, cj_n, ck_n, n_i, n_j, n_k, rr;
        logic signed [CW-1:0] hi_i, hi_j, hi_k, si, sj, sk;
        logic signed [1:0]    fi, fj, fk, rs;
        logic                 cand_in, last_box, last_st;
        logic [6:0]           okv;
        logic [3*DW+1:0]      idx_sum;

        state_next = state_reg;
        phase_next = phase_reg;
        qd_next    = qd_reg;
        qu_next    = qu_reg;
        r_next     = r_reg;
        ci_next    = ci_reg;
        cj_next    = cj_reg;
        ck_next    = ck_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        plane_next = plane_reg;
        oi_next    = oi_reg;
        oj_next    = oj_reg;
        ok_next    = ok_reg;
        step_next  = step_reg;
        ni_next    = ni_reg;
        nj_next    = nj_reg;
        nk_next    = nk_reg;
        last_next  = last_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;
        out_load   = 1'b0;

        // drop the held result once it is taken
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        // candidate cell from the center and the current offset
        ci_n = ci_reg[CW-1:0];
        cj_n = cj_reg[CW-1:0];
        ck_n = ck_reg[CW-1:0];
        rs   = {1'b0, r_reg};
        rr   = CW'(rs);
        if (qu_reg[0] == MODE_BOX)
        begin
            fi = oi_reg;
            fj = oj_reg;
            fk = ok_reg;
        end
        else
        begin
            fi = sten_off(step_reg, 2'd0);
            fj = sten_off(step_reg, 2'd1);
            fk = sten_off(step_reg, 2'd2);
        end
        n_i = ci_n + CW'(fi);
        n_j = cj_n + CW'(fj);
        n_k = ck_n + CW'(fk);
        cand_in = (n_i >= 0) && (n_i < $signed(CW'(d0))) &&
                  (n_j >= 0) && (n_j < $signed(CW'(d1))) &&
                  (n_k >= 0) && (n_k < $signed(CW'(d2)));

        // final box cell sits at the clamped upper corner
        hi_i = (ci_n + rr > $signed(CW'(d0)) - CW'(1)) ? $signed(CW'(d0)) - CW'(1) : ci_n + rr;
        hi_j = (cj_n + rr > $signed(CW'(d1)) - CW'(1)) ? $signed(CW'(d1)) - CW'(1) : cj_n + rr;
        hi_k = (ck_n + rr > $signed(CW'(d2)) - CW'(1)) ? $signed(CW'(d2)) - CW'(1) : ck_n + rr;
        last_box = (n_i == hi_i) && (n_j == hi_j) && (n_k == hi_k);

        // final stencil cell: no later stencil neighbor inside the grid
        okv = '0;
        for (int s = 1; s < 7; s++)
        begin
            si = ci_n + CW'(sten_off(3'(s), 2'd0));
            sj = cj_n + CW'(sten_off(3'(s), 2'd1));
            sk = ck_n + CW'(sten_off(3'(s), 2'd2));
            okv[s] = (si >= 0) && (si < $signed(CW'(d0))) &&
                     (sj >= 0) && (sj < $signed(CW'(d1))) &&
                     (sk >= 0) && (sk < $signed(CW'(d2))) && (3'(s) > step_reg);
        end
        last_st = (okv == '0);

        // world offset of the current axis
        unique case (phase_reg)
            PH_WY:   begin wpos = $signed(qd_reg[129:98]);  worg = org_y_reg; end
            PH_WZ:   begin wpos = $signed(qd_reg[161:130]); worg = org_z_reg; end
            default: begin wpos = $signed(qd_reg[97:66]);   worg = org_x_reg; end
        endcase
        wa = {wpos[31], wpos} - {worg[31], worg};

        idx_sum = (3*DW+2)'(ni_reg) + (3*DW+2)'(p1_reg) + (3*DW+2)'(p2_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                // take a query
                if (s_tvalid)
                begin
                    qd_next    = s_tdata;
                    qu_next    = s_tuser;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                plane_next = d0 * d1;
                if (qu_reg[2:1] == SRC_GRID)
                begin
                    r_next  = (MAX_RADIUS != 0) && (qd_reg[165:162] != 4'd0);
                    ci_next = CQW'($signed(qd_reg[11:0]));
                    cj_next = CQW'($signed(qd_reg[23:12]));
                    ck_next = CQW'($signed(qd_reg[35:24]));
                    state_next = S_CHECK;
                end
                else
                begin
                    r_next = (MAX_RADIUS != 0) && (qd_reg[196:166] >= h);
                    priority if (qu_reg[2:1] == SRC_INDEX)
                    begin
                        if (d0 == '0 || d1 == '0)
                        begin
                            state_next = S_EMPTY;
                        end
                        else
                        begin
                            // start z = index / plane
                            rem_next   = '0;
                            quo_next   = DIVW'(qd_reg[65:36]);
                            dvs_next   = 31'(d0 * d1);
                            cnt_next   = 6'(DIVW);
                            phase_next = PH_IDXZ;
                            state_next = S_DIV;
                        end
                    end
                    else if (qu_reg[2:1] == SRC_WORLD)
                    begin
                        phase_next = PH_WX;
                        state_next = S_WPREP;
                    end
                    else
                    begin
                        state_next = S_EMPTY;
                    end
                end
            end
            S_WPREP:
            begin
                // below the origin floors to a negative cell
                if (wa < 0)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = wa[DIVW-1:0];
                    dvs_next   = h;
                    cnt_next   = 6'(DIVW);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle
                rem_next = ge ? trial - {1'b0, dvs_reg} : trial;
                quo_next = {quo_reg[DIVW-2:0], ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_DIVDONE;
                end
            end
            S_DIVDONE:
            begin
                unique case (phase_reg)
                    PH_IDXZ:
                    begin
                        ck_next    = CQW'(quo_reg);
                        quo_next   = DIVW'(rem_reg);
                        rem_next   = '0;
                        dvs_next   = 31'(d0);
                        cnt_next   = 6'(DIVW);
                        phase_next = PH_IDXY;
                        state_next = S_DIV;
                    end
                    PH_IDXY:
                    begin
                        cj_next    = CQW'(quo_reg);
                        ci_next    = CQW'(rem_reg);
                        state_next = S_CHECK;
                    end
                    PH_WX:
                    begin
                        ci_next    = CQW'(quo_reg);
                        phase_next = PH_WY;
                        state_next = S_WPREP;
                    end
                    PH_WY:
                    begin
                        cj_next    = CQW'(quo_reg);
                        phase_next = PH_WZ;
                        state_next = S_WPREP;
                    end
                    default:
                    begin
                        ck_next    = CQW'(quo_reg);
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_CHECK:
            begin
                if ((ci_reg >= 0) && (ci_reg < $signed(CQW'(d0))) &&
                    (cj_reg >= 0) && (cj_reg < $signed(CQW'(d1))) &&
                    (ck_reg >= 0) && (ck_reg < $signed(CQW'(d2))))
                begin
                    oi_next    = -rs;
                    oj_next    = -rs;
                    ok_next    = -rs;
                    step_next  = '0;
                    state_next = S_CAND;
                end
                else
                begin
                    state_next = S_EMPTY;
                end
            end
            S_CAND:
            begin
                if (cand_in)
                begin
                    ni_next    = n_i[DW-1:0];
                    nj_next    = n_j[DW-1:0];
                    nk_next    = n_k[DW-1:0];
                    last_next  = (qu_reg[0] == MODE_BOX) ? last_box : last_st;
                    p1_next    = n_j[DW-1:0] * d0;
                    state_next = S_MUL2;
                end
                else
                begin
                    // skip a cell off the grid
                    if (oi_reg != rs)
                    begin
                        oi_next = oi_reg + 2'sd1;
                    end
                    else
                    begin
                        oi_next = -rs;
                        if (oj_reg != rs)
                        begin
                            oj_next = oj_reg + 2'sd1;
                        end
                        else
                        begin
                            oj_next = -rs;
                            ok_next = ok_reg + 2'sd1;
                        end
                    end
                    step_next = step_reg + 3'd1;
                end
            end
            S_MUL2:
            begin
                p2_next    = nk_reg * plane_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    mv_next  = 1'b1;
                    md_next  = {4'd0, idx_sum[29:0], 10'(nk_reg), 10'(nj_reg), 10'(ni_reg)};
                    mu_next  = 1'b0;
                    ml_next  = last_reg;
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // advance to the next candidate
                        if (oi_reg != rs)
                        begin
                            oi_next = oi_reg + 2'sd1;
                        end
                        else
                        begin
                            oi_next = -rs;
                            if (oj_reg != rs)
                            begin
                                oj_next = oj_reg + 2'sd1;
                            end
                            else
                            begin
                                oj_next = -rs;
                                ok_next = ok_reg + 2'sd1;
                            end
                        end
                        step_next  = step_reg + 3'd1;
                        state_next = S_CAND;
                    end
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    mv_next    = 1'b1;
                    md_next    = '0;
                    mu_next    = 1'b1;
                    ml_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // an empty result always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("empty result without last");

    // a result is loaded only into a free output slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!mv_reg || m_tready))
        else $error("output overwritten before transfer");

    // an accepted query starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_SETUP)
        else $error("query accepted without setup");

    // the divider never runs with a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg != 6'd0)
        else $error("divider count underflow");

endmodule

@@ tb/uniform_grid_neighbor_cells_core_tb.sv @@
// Testbench for the uniform grid neighbor cell search core: random and directed queries, scoreboarded.
`timescale 1ns / 100ps

module uniform_grid_neighbor_cells_core_tb;
    import ugnc_pkg::*;

    localparam int  MAX_DIM_TB    = 1024;
    localparam int  MAX_RADIUS_TB = 1;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct {
        logic               mode;
        logic [1:0]         source;
        logic signed [11:0] qi, qj, qk;
        logic [29:0]        qidx;
        logic signed [31:0] px, py, pz;
        logic [3:0]         rc;
        logic [30:0]        rw;
    } query_t;

    typedef struct packed {
        logic [9:0]  ci;
        logic [9:0]  cj;
        logic [9:0]  ck;
        logic [29:0] idx;
        logic        empty;
        logic        last;
    } cell_t;

    // Neighbor predictor and store of expected cells
    class neighbor_board;
        longint dim[3];
        longint org[3];
        longint spacing;
        cell_t  cells_due[$];
        int     fails;
        int     shown;
        int     off_x[7] = '{0, 1, -1, 0, 0, 0, 0};
        int     off_y[7] = '{0, 0, 0, 1, -1, 0, 0};
        int     off_z[7] = '{0, 0, 0, 0, 0, 1, -1};

        function void set_reg(logic [2:0] addr, logic [31:0] val);
            if (addr == REG_DIM_X || addr == REG_DIM_Y || addr == REG_DIM_Z)
                dim[addr] = val[10:0];
            else if (addr == REG_ORIGIN_X || addr == REG_ORIGIN_Y || addr == REG_ORIGIN_Z)
                org[addr - REG_ORIGIN_X] = longint'(signed'(val));
            else if (addr == REG_SPACING)
                spacing = val[30:0];
        endfunction

        function void add_cell(longint i, longint j, longint k, longint d[3]);
            cell_t c;
            longint lin;
            lin = i + j * d[0] + k * d[0] * d[1];
            c.ci = i[9:0];
            c.cj = j[9:0];
            c.ck = k[9:0];
            c.idx = lin[29:0];
            c.empty = 1'b0;
            c.last = 1'b0;
            cells_due = {cells_due, c};
        endfunction

        // Work out the cells one accepted query produces
        function void note_query(query_t q);
            longint d[3], c[3], nb[3], lo[3], hi[3];
            longint r, h, plane, rem, diff;
            bit ok, inb;
            cell_t e;
            r = 0;
            ok = 1;
            h = (spacing == 0) ? 1 : spacing;
            for (int a = 0; a < 3; a++)
                d[a] = (dim[a] > MAX_DIM_TB) ? MAX_DIM_TB : dim[a];
            c = '{0, 0, 0};
            if (q.source == SRC_GRID) begin
                c[0] = q.qi;
                c[1] = q.qj;
                c[2] = q.qk;
                r = q.rc;
            end
            else if (q.source == SRC_INDEX || q.source == SRC_WORLD) begin
                r = longint'(q.rw) / h;
                if (q.source == SRC_INDEX) begin
                    plane = d[0] * d[1];
                    if (plane == 0)
                        ok = 0;
                    else begin
                        rem = longint'(q.qidx) % plane;
                        c[2] = longint'(q.qidx) / plane;
                        c[1] = rem / d[0];
                        c[0] = rem % d[0];
                    end
                end
                else begin
                    for (int a = 0; a < 3; a++) begin
                        diff = longint'(a == 0 ? q.px : a == 1 ? q.py : q.pz) - org[a];
                        c[a] = diff / h;
                        if (diff % h != 0 && diff < 0)
                            c[a] = c[a] - 1;
                    end
                end
            end
            else
                ok = 0;
            if (r > MAX_RADIUS_TB)
                r = MAX_RADIUS_TB;
            inb = ok;
            for (int a = 0; a < 3; a++)
                if (c[a] < 0 || c[a] >= d[a])
                    inb = 0;
            if (!inb) begin
                e = '{ci: 0, cj: 0, ck: 0, idx: 0, empty: 1'b1, last: 1'b1};
                cells_due = {cells_due, e};
                return;
            end
            if (q.mode == MODE_BOX) begin
                for (int a = 0; a < 3; a++) begin
                    lo[a] = (c[a] - r < 0) ? 0 : c[a] - r;
                    hi[a] = (c[a] + r > d[a] - 1) ? d[a] - 1 : c[a] + r;
                end
                for (longint k = lo[2]; k <= hi[2]; k++)
                    for (longint j = lo[1]; j <= hi[1]; j++)
                        for (longint i = lo[0]; i <= hi[0]; i++)
                            add_cell(i, j, k, d);
            end
            else begin
                for (int s = 0; s < 7; s++) begin
                    nb[0] = c[0] + off_x[s];
                    nb[1] = c[1] + off_y[s];
                    nb[2] = c[2] + off_z[s];
                    if (nb[0] >= 0 && nb[0] < d[0] && nb[1] >= 0 && nb[1] < d[1] &&
                        nb[2] >= 0 && nb[2] < d[2])
                        add_cell(nb[0], nb[1], nb[2], d);
                end
            end
            cells_due[cells_due.size() - 1].last = 1'b1;
        endfunction

        // Compare one emitted cell against the oldest expectation
        function void check_result(cell_t got);
            cell_t want;
            if (cells_due.size() == 0) begin
                fails++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result: i=%0d j=%0d k=%0d idx=%0d empty=%0b last=%0b",
                             got.ci, got.cj, got.ck, got.idx, got.empty, got.last);
                end
                return;
            end
            want = cells_due.pop_front();
            if (got != want) begin
                fails++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch: expected i=%0d j=%0d k=%0d idx=%0d empty=%0b last=%0b",
                             want.ci, want.cj, want.ck, want.idx, want.empty, want.last);
                    $display("          actual   i=%0d j=%0d k=%0d idx=%0d empty=%0b last=%0b",
                             got.ci, got.cj, got.ck, got.idx, got.empty, got.last);
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // query_i, query_j, query_k, query_index, pos_x, pos_y, pos_z, radius_cells, radius_world
    logic [199:0] s_tdata;
    // mode, source
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // cell_i, cell_j, cell_k, cell_index
    logic [63:0]  m_tdata;
    // empty_res
    logic         m_tuser;
    logic         m_tlast;

    neighbor_board board;
    int     send_idle;
    int     recv_idle;
    bit     hold_req;
    int     hold_left;
    longint cycles;

    uniform_grid_neighbor_cells_core #(
        .MAX_DIM    (MAX_DIM_TB),
        .MAX_RADIUS (MAX_RADIUS_TB)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Abort on a hung run
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("uniform_grid_neighbor_cells_core verification failed");
            $finish;
        end
    end

    // Drive the receiver ready, with long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Check every result transfer
    always @(posedge clk)
    begin
        cell_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.ci = m_tdata[9:0];
            got.cj = m_tdata[19:10];
            got.ck = m_tdata[29:20];
            got.idx = m_tdata[59:30];
            got.empty = m_tuser;
            got.last = m_tlast;
            board.check_result(got);
        end
    end

    // Offer one query and hold it until the transfer; entered and left at a falling edge
    task automatic send_query(query_t q);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {q.source, q.mode};
        s_tdata  <= {3'b000, q.rw, q.rc, q.pz, q.py, q.px, q.qidx, q.qk, q.qj, q.qi};
        do @(posedge clk); while (!s_tready);
        board.note_query(q);
        @(negedge clk);
    endtask

    task automatic dq(logic mode, logic [1:0] src, int i, int j, int k, logic [29:0] idx,
                      logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                      logic [3:0] rc, logic [30:0] rw);
        query_t q;
        q = '{mode: mode, source: src, qi: i[11:0], qj: j[11:0], qk: k[11:0], qidx: idx,
              px: px, py: py, pz: pz, rc: rc, rw: rw};
        send_query(q);
    endtask

    // Wait until every expected cell has come out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.cells_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_grid(logic [31:0] regs[7]);
        for (int a = 0; a < 7; a++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= a[2:0];
            cfg_data <= regs[a];
            board.set_reg(a[2:0], regs[a]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int near_coord(longint d);
        if ($urandom_range(9) < 8)
            return $urandom_range(32'(d + 3)) - 2;
        return $urandom;
    endfunction

    // Mostly queries aimed at and around the grid, some raw noise
    function automatic query_t build_query();
        query_t q;
        longint grid_c, pos;
        logic [31:0] p[3];
        int pick;
        q.mode = 1'($urandom);
        pick = $urandom_range(99);
        q.source = (pick < 32) ? SRC_GRID : (pick < 64) ? SRC_INDEX :
                   (pick < 95) ? SRC_WORLD : SRC_UNUSED;
        q.qi = 12'($urandom); q.qj = 12'($urandom); q.qk = 12'($urandom);
        q.qidx = 30'($urandom); q.px = $urandom; q.py = $urandom; q.pz = $urandom;
        q.rc = 4'($urandom); q.rw = 31'($urandom);
        if ($urandom_range(9) < 8) begin
            q.qi = 12'(near_coord(board.dim[0]));
            q.qj = 12'(near_coord(board.dim[1]));
            q.qk = 12'(near_coord(board.dim[2]));
            q.rc = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(2));
            q.qidx = 30'($urandom_range(32'(board.dim[0] * board.dim[1] * board.dim[2] + 2)));
            for (int a = 0; a < 3; a++) begin
                grid_c = near_coord(board.dim[a]);
                pos = board.org[a] + grid_c * board.spacing +
                      (board.spacing > 0 ? longint'($urandom) % board.spacing : 0);
                p[a] = pos[31:0];
            end
            q.px = p[0]; q.py = p[1]; q.pz = p[2];
            if ($urandom_range(1) == 0)
                q.rw = 31'(board.spacing * $urandom_range(2) + $urandom_range(1));
        end
        return q;
    endfunction

    initial
    begin
        logic [31:0] grids[6][7];
        board = new();
        board.fails = 0;
        board.shown = 0;
        board.dim = '{0, 0, 0};
        board.org = '{0, 0, 0};
        board.spacing = 65536;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        hold_req = 0;
        hold_left = 0;
        send_idle = 8;
        recv_idle = 46;
        grids[0] = '{4, 3, 5, 0, 0, 0, 32'h0001_0000};
        grids[1] = '{2047, 2, 1024, 32'h8000_0000, 32'h7FFF_FFFF, 12345, 1};
        grids[2] = '{1, 1, 1, 0, 0, 0, 32'h7FFF_FFFF};
        grids[3] = '{3, 3, 3, -100, -100, -100, 0};
        grids[4] = '{0, 5, 5, 0, 0, 0, 32'h0003_0000};
        grids[5] = '{6, 2, 3, 32'h0001_8000, 32'hFFFF_0000, 0, 32'h0000_8000};
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed queries against a 4x3x5 grid with unit spacing
        set_grid(grids[0]);
        dq(MODE_BOX, SRC_GRID, 1, 1, 2, 0, 0, 0, 0, 0, 0);
        dq(MODE_BOX, SRC_GRID, 1, 1, 2, 0, 0, 0, 0, 1, 0);
        dq(MODE_BOX, SRC_GRID, 2, 1, 2, 0, 0, 0, 0, 15, 0);
        dq(MODE_BOX, SRC_GRID, 0, 0, 0, 0, 0, 0, 0, 15, 0);
        dq(MODE_BOX, SRC_GRID, 3, 2, 4, 0, 0, 0, 0, 1, 0);
        dq(MODE_BOX, SRC_GRID, -1, 0, 0, 0, 0, 0, 0, 1, 0);
        dq(MODE_BOX, SRC_GRID, 4, 0, 0, 0, 0, 0, 0, 1, 0);
        dq(MODE_STENCIL, SRC_GRID, -2048, 2047, 0, 0, 0, 0, 0, 0, 0);
        dq(MODE_STENCIL, SRC_GRID, 1, 1, 2, 0, 0, 0, 0, 0, 0);
        dq(MODE_STENCIL, SRC_GRID, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        dq(MODE_STENCIL, SRC_GRID, 3, 2, 4, 0, 0, 0, 0, 0, 0);
        dq(MODE_BOX, SRC_INDEX, 0, 0, 0, 0, 0, 0, 0, 0, 65536);
        dq(MODE_BOX, SRC_INDEX, 0, 0, 0, 59, 0, 0, 0, 0, 31'h7FFF_FFFF);
        dq(MODE_BOX, SRC_INDEX, 0, 0, 0, 60, 0, 0, 0, 0, 0);
        dq(MODE_STENCIL, SRC_INDEX, 0, 0, 0, 30'h3FFF_FFFF, 0, 0, 0, 0, 0);
        dq(MODE_STENCIL, SRC_INDEX, 0, 0, 0, 17, 0, 0, 0, 0, 0);
        dq(MODE_BOX, SRC_WORLD, 0, 0, 0, 0, 0, 0, 0, 0, 65535);
        dq(MODE_BOX, SRC_WORLD, 0, 0, 0, 0, 32'h0001_8000, 32'h0001_FFFF, 32'h0003_0000,
           0, 65536);
        dq(MODE_BOX, SRC_WORLD, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 65536);
        dq(MODE_STENCIL, SRC_WORLD, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        dq(MODE_STENCIL, SRC_WORLD, 0, 0, 0, 0, 32'h0003_0000, 32'h0002_0000, 32'h0004_0000,
           0, 0);
        dq(MODE_BOX, SRC_UNUSED, 1, 1, 1, 1, 0, 0, 0, 1, 65536);
        drain();

        // Random queries across several grid settings and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle = 46;
                recv_idle = 8;
            end
            else if (ph == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_grid(grids[ph]);
            for (int n = 0; n < 73; n++) begin
                if (ph == 1 && n == 20) begin
                    @(posedge clk);
                    hold_req = 1;
                    @(negedge clk);
                end
                if (ph == 3 && n == 40) begin
                    s_tvalid <= 1'b0;
                    while (board.cells_due.size() != 0)
                        @(negedge clk);
                end
                send_query(build_query());
            end
            drain();
        end

        repeat (50) @(negedge clk);
        board.fails += board.cells_due.size();
        if (board.fails == 0)
            $display("uniform_grid_neighbor_cells_core verification clean");
        else
            $display("uniform_grid_neighbor_cells_core verification failed");
        $finish;
    end

endmodule
